// ===== hdl/ddq_pkg.sv =====
// ----------------------------------------------------------------------------
// ddq_pkg
// Shared types and constants of the double-ended queue: the transaction
// payloads on both channels, the operation and status codes, and the control
// group that drives one storage chain.
// ----------------------------------------------------------------------------
package ddq_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int VALUE_W = 32;
    localparam int ECNT_W  = 7;

    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_POP   = 1'b1;
    localparam logic SIDE_FRONT = 1'b0;
    localparam logic SIDE_BACK  = 1'b1;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                      kind;
        logic                      side;
        logic signed [VALUE_W-1:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        logic [1:0]                status;
        logic                      is_empty;
        logic [ECNT_W-1:0]         entry_count;
    } t_out_item;

    // One chain keeps the queue with its own end at cell 0. push_head shifts
    // every cell one place away from cell 0 and loads the new value there;
    // pop_head shifts toward cell 0; push_tail writes the cell just past the
    // last held entry.
    typedef struct packed {
        logic push_head;
        logic pop_head;
        logic push_tail;
    } t_chain_ctl;

endpackage

// ===== hdl/ddq_cell.sv =====
// ----------------------------------------------------------------------------
// ddq_cell
// One storage cell of a chain: holds a single entry and takes its next value
// from the left neighbor, the right neighbor or the broadcast write value.
// ----------------------------------------------------------------------------
module ddq_cell (
    input  logic                                 i_clk,
    input  ddq_pkg::t_chain_ctl                  i_ctl,
    input  logic                                 i_load,
    input  logic signed [ddq_pkg::VALUE_W-1:0]   i_load_value,
    input  logic signed [ddq_pkg::VALUE_W-1:0]   i_from_left,
    input  logic signed [ddq_pkg::VALUE_W-1:0]   i_from_right,
    output logic signed [ddq_pkg::VALUE_W-1:0]   o_value
);
    import ddq_pkg::*;

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_load) begin
            n_value = i_load_value;
        end else if (i_ctl.push_head) begin
            n_value = i_from_left;
        end else if (i_ctl.pop_head) begin
            n_value = i_from_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

// ===== hdl/ddq_chain.sv =====
// ----------------------------------------------------------------------------
// ddq_chain
// A row of DEPTH cells holding the queue with one end at cell 0. Shifts move
// every cell to its neighbor; a tail write is decoded per cell against the
// current fill count.
// ----------------------------------------------------------------------------
module ddq_chain #(
    parameter int DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
    input  logic                                 i_clk,
    input  ddq_pkg::t_chain_ctl                  i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0]           i_count,
    input  logic signed [ddq_pkg::VALUE_W-1:0]   i_value,
    output logic signed [ddq_pkg::VALUE_W-1:0]   o_head
);
    import ddq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] cell_q [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [VALUE_W-1:0] from_left;
        logic signed [VALUE_W-1:0] from_right;
        logic                      load;

        if (g == 0) begin : g_first
            assign from_left = i_value;
        end else begin : g_mid_l
            assign from_left = cell_q[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign from_right = cell_q[g];
        end else begin : g_mid_r
            assign from_right = cell_q[g+1];
        end

        // The cell just past the held entries takes a write at the far end.
        assign load = i_ctl.push_tail && (i_count == CNT_W'(g));

        ddq_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_load       (load),
            .i_load_value (i_value),
            .i_from_left  (from_left),
            .i_from_right (from_right),
            .o_value      (cell_q[g])
        );
    end

    assign o_head = cell_q[0];

endmodule

// ===== hdl/double_ended_queue_core.sv =====
// ----------------------------------------------------------------------------
// double_ended_queue_core
// Output: each result is registered and presented in the cycle after its input
// transaction. Throughput: one transaction per cycle while the receiver takes
// every result; a result held by the receiver blocks the input until it is
// taken. An operation is one chain shift, plus a one-cell write for a push.
// Reset: i_rst_n is synchronous, active low; it empties the queue and drops
// any pending result. Cell contents are not cleared and need no sweep.
// ----------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH = ddq_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddq_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ddq_pkg::t_out_item o_out_item
);
    import ddq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // The queue is kept twice, in two chains of identical cells. The front
    // chain holds the entries in order with the front entry in its cell 0;
    // the back chain holds them in reverse order with the back entry in its
    // cell 0. A push at one end shifts that end's chain and writes the other
    // chain at the cell just past its last entry; a pop shifts only its own chain.
    // Both ends are always readable at a fixed cell; no wide read select is needed.

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_item        r_out_item;
    t_out_item        n_out_item;

    logic             in_accept;
    logic             is_pop;
    logic             at_back;
    logic             q_empty;
    logic             q_full;
    logic             do_push;
    logic             do_pop;

    t_chain_ctl                front_ctl;
    t_chain_ctl                back_ctl;
    logic signed [VALUE_W-1:0] front_head;
    logic signed [VALUE_W-1:0] back_head;

    // The output register frees itself in the same cycle it is taken, so a
    // new transaction is accepted whenever the result slot is empty or is
    // being drained.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    assign is_pop  = (i_in_item.kind == KIND_POP);
    assign at_back = (i_in_item.side == SIDE_BACK);
    assign q_empty = (r_count == '0);
    assign q_full  = (r_count == CNT_W'(DEPTH));

    // Only operations that actually change the queue drive the chains.
    assign do_push = in_accept && !is_pop && !q_full;
    assign do_pop  = in_accept && is_pop && !q_empty;

    always_comb begin
        front_ctl.push_head = do_push && !at_back;
        front_ctl.pop_head  = do_pop && !at_back;
        front_ctl.push_tail = do_push && at_back;

        back_ctl.push_head  = do_push && at_back;
        back_ctl.pop_head   = do_pop && at_back;
        back_ctl.push_tail  = do_push && !at_back;
    end

    ddq_chain #(
        .DEPTH (DEPTH)
    ) u_front_chain (
        .i_clk   (i_clk),
        .i_ctl   (front_ctl),
        .i_count (r_count),
        .i_value (i_in_item.push_value),
        .o_head  (front_head)
    );

    ddq_chain #(
        .DEPTH (DEPTH)
    ) u_back_chain (
        .i_clk   (i_clk),
        .i_ctl   (back_ctl),
        .i_count (r_count),
        .i_value (i_in_item.push_value),
        .o_head  (back_head)
    );

    // Next fill count and the result of the accepted transaction. A rejected
    // push or a pop on an empty queue leaves the count alone and returns zero.
    always_comb begin
        n_count = r_count;
        if (do_push) begin
            n_count = r_count + 1'b1;
        end else if (do_pop) begin
            n_count = r_count - 1'b1;
        end

        n_out_item.pop_value = '0;
        n_out_item.status    = ST_DONE;
        if (is_pop) begin
            if (q_empty) begin
                n_out_item.status = ST_EMPTY;
            end else if (at_back) begin
                n_out_item.pop_value = back_head;
            end else begin
                n_out_item.pop_value = front_head;
            end
        end else if (q_full) begin
            n_out_item.status = ST_FULL;
        end
        n_out_item.is_empty    = (n_count == '0);
        n_out_item.entry_count = ECNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (in_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`ifndef NO_ASSERTIONS
    // The fill count can never pass the capacity of the chains.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // A stalled result must block new transactions.
    a_stall_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result stalled");

    // A successful pop takes exactly one entry away.
    a_pop_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && is_pop && !q_empty) |=> (r_count == $past(r_count) - 1'b1))
        else $error("pop did not decrement the fill count");

    // A rejected push is only reported while the queue is full.
    a_full_status : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == ST_FULL) |-> q_full)
        else $error("full status reported with free entries");

    // The two ends never see a push and a pop in the same cycle.
    a_single_op : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({front_ctl.push_head, front_ctl.pop_head, front_ctl.push_tail,
                  back_ctl.pop_head}))
        else $error("conflicting chain controls");
`endif

endmodule
